// File: design/pamt_pkg.sv
// ---------------------------------------------------------------------------
// pamt_pkg: shared types and constants for the page alias mapping table
// Sizes, request and status codes, payload structs and controller commands.
// ---------------------------------------------------------------------------
`default_nettype none

package pamt_pkg;

   localparam int NUM_FRAMES      = 256;
   localparam int SLOTS_PER_FRAME = 32;
   localparam int TOTAL_SLOTS     = NUM_FRAMES * SLOTS_PER_FRAME;
   localparam int FW              = $clog2(NUM_FRAMES);
   localparam int SW              = $clog2(SLOTS_PER_FRAME);
   localparam int PW              = SW + 1;
   localparam int AW              = $clog2(TOTAL_SLOTS);
   localparam int CW              = $clog2(SLOTS_PER_FRAME + 1);
   localparam int SLOT_BITS       = 16 + 32 + PW;

   typedef enum logic [1:0] {
      REQ_GET     = 2'd0,
      REQ_ALIAS   = 2'd1,
      REQ_REVOKE  = 2'd2,
      REQ_RELEASE = 2'd3
   } rtype_type;

   typedef enum logic [2:0] {
      CODE_OK        = 3'd0,
      CODE_NO_FRAME  = 3'd1,
      CODE_REFUSED   = 3'd2,
      CODE_NO_SOURCE = 3'd3,
      CODE_NO_SLOT   = 3'd4,
      CODE_NOT_FOUND = 3'd5
   } code_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] owner;
      logic [31:0] vaddr;
      logic [15:0] dest_owner;
      logic [31:0] dest_vaddr;
      logic        grant_ok;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] mapped_vaddr;
      logic [7:0]  frame;
      logic [4:0]  slot;
      logic        is_revoke;
      logic [15:0] revoke_owner;
      logic [31:0] revoke_vaddr;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic [15:0]   owner;
      logic [31:0]   vaddr;
      logic [PW-1:0] parent;
   } slot_type;

   typedef enum logic [4:0] {
      OP_HOLD,
      OP_CLEAR,
      OP_LOAD,
      OP_NEXT_FR,
      OP_NEXT_SL,
      OP_CHK_CNT,
      OP_HIT,
      OP_CAP_NEXT,
      OP_WALK_INIT,
      OP_WALK_STEP,
      OP_KILL,
      OP_EMIT_ZERO,
      OP_EMIT_FR,
      OP_EMIT_FS,
      OP_EMIT_FD,
      OP_GET_WR,
      OP_ALIAS_WR,
      OP_REV_DONE,
      OP_REL_DONE
   } op_type;

   typedef struct packed {
      op_type   op;
      code_type code;
   } cmd_type;

   typedef struct packed {
      rtype_type rtype;
      logic      clr_last;
      logic      cnt_zero;
      logic      match;
      logic      slot_free;
      logic      sl_is_s;
      logic      sl_last;
      logic      fr_last;
      logic      get_bad;
      logic      src_bad;
      logic      dst_bad;
      logic      grant_ok;
      logic      skip;
      logic      w_stop;
      logic      w_hit;
      logic      w_exh;
   } stat_type;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_DISPATCH,
      S_GF_RD,
      S_GF_CK,
      S_FM_CRD,
      S_FM_CCK,
      S_FM_SRD,
      S_FM_SCK,
      S_AL_RD,
      S_AL_CK,
      S_LD_RD,
      S_LD_CAP,
      S_WK_CHILD,
      S_WK_STEP,
      S_FIN
   } state_type;

endpackage

`default_nettype wire

// File: design/pamt_ram.sv
// ---------------------------------------------------------------------------
// pamt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module pamt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// File: design/pamt_datapath.sv
// ---------------------------------------------------------------------------
// pamt_datapath: slot storage, frame copy, walk unit and result register
// Executes one controller command per cycle and reports status flags.
// ---------------------------------------------------------------------------
`default_nettype none

module pamt_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pamt_pkg::req_item_type req_item,
   input  wire pamt_pkg::cmd_type     cmd,
   output      pamt_pkg::stat_type    stat,
   output      logic                  rsp_strobe,
   output      pamt_pkg::rsp_item_type rsp_item
);

   localparam int S  = pamt_pkg::SLOTS_PER_FRAME;
   localparam int SW = pamt_pkg::SW;
   localparam int PW = pamt_pkg::PW;
   localparam int FW = pamt_pkg::FW;
   localparam int AW = pamt_pkg::AW;
   localparam int CW = pamt_pkg::CW;

   pamt_pkg::req_item_type req_ff;
   logic [FW-1:0]          fr_ff;
   logic [SW-1:0]          sl_ff;
   logic [SW-1:0]          s_ff;
   logic [AW-1:0]          clr_ff;
   logic [CW-1:0]          use_ff;
   logic [SW-1:0]          cur_ff;
   logic [SW-1:0]          step_ff;
   logic [15:0]            own_ff [S];
   logic [31:0]            va_ff  [S];
   logic [PW-1:0]          par_ff [S];
   logic                   strobe_ff;
   pamt_pkg::rsp_item_type rsp_ff;

   logic                   strobe_in;
   pamt_pkg::rsp_item_type rsp_in;
   logic [SW-1:0]          sl_nx;
   logic [PW-1:0]          p;
   logic [CW-1:0]          use_dec;

   logic                   s_we;
   logic [AW-1:0]          s_waddr;
   pamt_pkg::slot_type     s_wdata;
   logic [AW-1:0]          s_raddr;
   pamt_pkg::slot_type     s_rdata;
   logic                   c_we;
   logic [FW-1:0]          c_waddr;
   logic [CW-1:0]          c_wdata;
   logic [CW-1:0]          c_rdata;

   pamt_ram #(.WIDTH(pamt_pkg::SLOT_BITS), .DEPTH(pamt_pkg::TOTAL_SLOTS)) u_slot_ram (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata),
      .rd_addr (s_raddr),
      .rd_data (s_rdata)
   );

   pamt_ram #(.WIDTH(CW), .DEPTH(pamt_pkg::NUM_FRAMES)) u_count_ram (
      .clock   (clock),
      .wr_en   (c_we),
      .wr_addr (c_waddr),
      .wr_data (c_wdata),
      .rd_addr (fr_ff),
      .rd_data (c_rdata)
   );

   assign s_raddr = AW'(fr_ff) * AW'(S) + AW'(sl_ff);
   assign sl_nx   = (sl_ff == SW'(S - 1)) ? '0 : sl_ff + 1'b1;
   assign p       = par_ff[cur_ff];
   assign use_dec = (use_ff == '0) ? '0 : use_ff - 1'b1;

   always_comb begin
      stat.rtype     = pamt_pkg::rtype_type'(req_ff.req_type);
      stat.clr_last  = clr_ff == AW'(pamt_pkg::TOTAL_SLOTS - 1);
      stat.cnt_zero  = c_rdata == '0;
      stat.match     = s_rdata.owner == req_ff.owner && s_rdata.vaddr == req_ff.vaddr;
      stat.slot_free = s_rdata.owner == '0;
      stat.sl_is_s   = sl_ff == s_ff;
      stat.sl_last   = sl_ff == SW'(S - 1);
      stat.fr_last   = fr_ff == FW'(pamt_pkg::NUM_FRAMES - 1);
      stat.get_bad   = req_ff.owner == '0 || req_ff.vaddr == '0;
      stat.src_bad   = req_ff.owner == '0;
      stat.dst_bad   = req_ff.dest_owner == '0 || req_ff.dest_vaddr == '0 || !req_ff.grant_ok;
      stat.grant_ok  = req_ff.grant_ok;
      stat.skip      = sl_ff == s_ff || own_ff[sl_ff] == '0;
      stat.w_stop    = p >= PW'(S) || p == PW'(cur_ff);
      stat.w_hit     = p == PW'(s_ff);
      stat.w_exh     = step_ff == SW'(S - 1);
   end

   always_comb begin
      s_we      = 1'b0;
      s_waddr   = AW'(fr_ff) * AW'(S) + AW'(sl_ff);
      s_wdata   = '0;
      c_we      = 1'b0;
      c_waddr   = fr_ff;
      c_wdata   = '0;
      strobe_in = 1'b0;
      rsp_in    = '0;
      rsp_in.last  = 1'b1;
      rsp_in.frame = 8'(fr_ff);
      unique case (cmd.op)
         pamt_pkg::OP_CLEAR: begin
            s_we    = 1'b1;
            s_waddr = clr_ff;
            c_we    = 1'b1;
            c_waddr = clr_ff[FW-1:0];
         end
         pamt_pkg::OP_EMIT_ZERO: begin
            strobe_in     = 1'b1;
            rsp_in.status = cmd.code;
            rsp_in.frame  = '0;
         end
         pamt_pkg::OP_EMIT_FR: begin
            strobe_in     = 1'b1;
            rsp_in.status = cmd.code;
         end
         pamt_pkg::OP_EMIT_FS: begin
            strobe_in     = 1'b1;
            rsp_in.status = cmd.code;
            rsp_in.slot   = 5'(s_ff);
         end
         pamt_pkg::OP_EMIT_FD: begin
            strobe_in     = 1'b1;
            rsp_in.status = cmd.code;
            rsp_in.slot   = 5'(sl_ff);
         end
         pamt_pkg::OP_GET_WR: begin
            s_we    = 1'b1;
            s_waddr = AW'(fr_ff) * AW'(S);
            s_wdata = '{owner: req_ff.owner, vaddr: req_ff.vaddr, parent: '0};
            c_we    = 1'b1;
            c_wdata = CW'(1);
            strobe_in           = 1'b1;
            rsp_in.status       = pamt_pkg::CODE_OK;
            rsp_in.mapped_vaddr = req_ff.vaddr;
         end
         pamt_pkg::OP_ALIAS_WR: begin
            s_we    = 1'b1;
            s_wdata = '{owner: req_ff.dest_owner, vaddr: req_ff.dest_vaddr,
                        parent: PW'(s_ff)};
            c_we    = 1'b1;
            c_wdata = use_ff + 1'b1;
            strobe_in           = 1'b1;
            rsp_in.status       = pamt_pkg::CODE_OK;
            rsp_in.mapped_vaddr = req_ff.dest_vaddr;
            rsp_in.slot         = 5'(sl_ff);
         end
         pamt_pkg::OP_KILL: begin
            s_we = 1'b1;
            strobe_in           = 1'b1;
            rsp_in.status       = pamt_pkg::CODE_OK;
            rsp_in.slot         = 5'(sl_ff);
            rsp_in.is_revoke    = 1'b1;
            rsp_in.revoke_owner = own_ff[sl_ff];
            rsp_in.revoke_vaddr = va_ff[sl_ff];
            rsp_in.last         = 1'b0;
         end
         pamt_pkg::OP_REV_DONE: begin
            c_we    = 1'b1;
            c_wdata = use_ff;
            strobe_in     = 1'b1;
            rsp_in.status = pamt_pkg::CODE_OK;
            rsp_in.slot   = 5'(s_ff);
         end
         pamt_pkg::OP_REL_DONE: begin
            s_we    = 1'b1;
            s_waddr = AW'(fr_ff) * AW'(S) + AW'(s_ff);
            c_we    = 1'b1;
            c_wdata = use_dec;
            strobe_in           = 1'b1;
            rsp_in.status       = pamt_pkg::CODE_OK;
            rsp_in.slot         = 5'(s_ff);
            rsp_in.is_revoke    = 1'b1;
            rsp_in.revoke_owner = req_ff.owner;
            rsp_in.revoke_vaddr = req_ff.vaddr;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
         if (cmd.op == pamt_pkg::OP_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (strobe_in) begin
         rsp_ff <= rsp_in;
      end
      unique case (cmd.op)
         pamt_pkg::OP_LOAD: begin
            req_ff <= req_item;
            fr_ff  <= '0;
            sl_ff  <= '0;
         end
         pamt_pkg::OP_NEXT_FR: begin
            fr_ff <= fr_ff + 1'b1;
            sl_ff <= '0;
         end
         pamt_pkg::OP_NEXT_SL: begin
            sl_ff <= sl_nx;
         end
         pamt_pkg::OP_CHK_CNT: begin
            use_ff <= c_rdata;
         end
         pamt_pkg::OP_HIT: begin
            s_ff  <= sl_ff;
            sl_ff <= '0;
         end
         pamt_pkg::OP_CAP_NEXT: begin
            own_ff[sl_ff] <= s_rdata.owner;
            va_ff[sl_ff]  <= s_rdata.vaddr;
            par_ff[sl_ff] <= s_rdata.parent;
            sl_ff         <= sl_nx;
         end
         pamt_pkg::OP_WALK_INIT: begin
            cur_ff  <= sl_ff;
            step_ff <= '0;
         end
         pamt_pkg::OP_WALK_STEP: begin
            cur_ff  <= p[SW-1:0];
            step_ff <= step_ff + 1'b1;
         end
         pamt_pkg::OP_KILL: begin
            use_ff <= use_dec;
            sl_ff  <= sl_nx;
         end
         default: begin
         end
      endcase
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

`default_nettype wire

// File: design/pamt_ctrl.sv
// ---------------------------------------------------------------------------
// pamt_ctrl: request sequencer
// Clears the table after reset, then steps each request through its scans.
// ---------------------------------------------------------------------------
`default_nettype none

module pamt_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output      logic               busy,
   input  wire pamt_pkg::stat_type stat,
   output      pamt_pkg::cmd_type  cmd
);

   pamt_pkg::state_type state_ff;
   pamt_pkg::state_type state_in;
   pamt_pkg::code_type  nf_code;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pamt_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy    = state_ff != pamt_pkg::S_IDLE;
   assign nf_code = (stat.rtype == pamt_pkg::REQ_ALIAS) ? pamt_pkg::CODE_NO_SOURCE
                                                        : pamt_pkg::CODE_NOT_FOUND;

   always_comb begin
      state_in = state_ff;
      cmd.op   = pamt_pkg::OP_HOLD;
      cmd.code = pamt_pkg::CODE_OK;
      unique case (state_ff)
         pamt_pkg::S_CLEAR: begin
            cmd.op = pamt_pkg::OP_CLEAR;
            if (stat.clr_last) state_in = pamt_pkg::S_IDLE;
         end
         pamt_pkg::S_IDLE: begin
            if (start) begin
               cmd.op   = pamt_pkg::OP_LOAD;
               state_in = pamt_pkg::S_DISPATCH;
            end
         end
         pamt_pkg::S_DISPATCH: begin
            priority if (stat.rtype == pamt_pkg::REQ_GET) begin
               if (stat.get_bad) begin
                  cmd.op   = pamt_pkg::OP_EMIT_ZERO;
                  cmd.code = pamt_pkg::CODE_REFUSED;
                  state_in = pamt_pkg::S_IDLE;
               end else begin
                  state_in = pamt_pkg::S_GF_RD;
               end
            end else if (stat.src_bad) begin
               cmd.op   = pamt_pkg::OP_EMIT_ZERO;
               cmd.code = nf_code;
               state_in = pamt_pkg::S_IDLE;
            end else begin
               state_in = pamt_pkg::S_FM_CRD;
            end
         end
         pamt_pkg::S_GF_RD: state_in = pamt_pkg::S_GF_CK;
         pamt_pkg::S_GF_CK: begin
            priority if (stat.cnt_zero) begin
               if (stat.grant_ok) begin
                  cmd.op = pamt_pkg::OP_GET_WR;
               end else begin
                  cmd.op   = pamt_pkg::OP_EMIT_FR;
                  cmd.code = pamt_pkg::CODE_REFUSED;
               end
               state_in = pamt_pkg::S_IDLE;
            end else if (stat.fr_last) begin
               cmd.op   = pamt_pkg::OP_EMIT_ZERO;
               cmd.code = pamt_pkg::CODE_NO_FRAME;
               state_in = pamt_pkg::S_IDLE;
            end else begin
               cmd.op   = pamt_pkg::OP_NEXT_FR;
               state_in = pamt_pkg::S_GF_RD;
            end
         end
         pamt_pkg::S_FM_CRD: state_in = pamt_pkg::S_FM_CCK;
         pamt_pkg::S_FM_CCK: begin
            priority if (!stat.cnt_zero) begin
               cmd.op   = pamt_pkg::OP_CHK_CNT;
               state_in = pamt_pkg::S_FM_SRD;
            end else if (stat.fr_last) begin
               cmd.op   = pamt_pkg::OP_EMIT_ZERO;
               cmd.code = nf_code;
               state_in = pamt_pkg::S_IDLE;
            end else begin
               cmd.op   = pamt_pkg::OP_NEXT_FR;
               state_in = pamt_pkg::S_FM_CRD;
            end
         end
         pamt_pkg::S_FM_SRD: state_in = pamt_pkg::S_FM_SCK;
         pamt_pkg::S_FM_SCK: begin
            priority if (stat.match) begin
               cmd.op   = pamt_pkg::OP_HIT;
               state_in = (stat.rtype == pamt_pkg::REQ_ALIAS) ? pamt_pkg::S_AL_RD
                                                              : pamt_pkg::S_LD_RD;
            end else if (!stat.sl_last) begin
               cmd.op   = pamt_pkg::OP_NEXT_SL;
               state_in = pamt_pkg::S_FM_SRD;
            end else if (stat.fr_last) begin
               cmd.op   = pamt_pkg::OP_EMIT_ZERO;
               cmd.code = nf_code;
               state_in = pamt_pkg::S_IDLE;
            end else begin
               cmd.op   = pamt_pkg::OP_NEXT_FR;
               state_in = pamt_pkg::S_FM_CRD;
            end
         end
         pamt_pkg::S_AL_RD: state_in = pamt_pkg::S_AL_CK;
         pamt_pkg::S_AL_CK: begin
            priority if (stat.slot_free && !stat.sl_is_s) begin
               if (stat.dst_bad) begin
                  cmd.op   = pamt_pkg::OP_EMIT_FD;
                  cmd.code = pamt_pkg::CODE_REFUSED;
               end else begin
                  cmd.op = pamt_pkg::OP_ALIAS_WR;
               end
               state_in = pamt_pkg::S_IDLE;
            end else if (stat.sl_last) begin
               cmd.op   = pamt_pkg::OP_EMIT_FS;
               cmd.code = pamt_pkg::CODE_NO_SLOT;
               state_in = pamt_pkg::S_IDLE;
            end else begin
               cmd.op   = pamt_pkg::OP_NEXT_SL;
               state_in = pamt_pkg::S_AL_RD;
            end
         end
         pamt_pkg::S_LD_RD: state_in = pamt_pkg::S_LD_CAP;
         pamt_pkg::S_LD_CAP: begin
            cmd.op   = pamt_pkg::OP_CAP_NEXT;
            state_in = stat.sl_last ? pamt_pkg::S_WK_CHILD : pamt_pkg::S_LD_RD;
         end
         pamt_pkg::S_WK_CHILD: begin
            if (stat.skip) begin
               cmd.op   = pamt_pkg::OP_NEXT_SL;
               state_in = stat.sl_last ? pamt_pkg::S_FIN : pamt_pkg::S_WK_CHILD;
            end else begin
               cmd.op   = pamt_pkg::OP_WALK_INIT;
               state_in = pamt_pkg::S_WK_STEP;
            end
         end
         pamt_pkg::S_WK_STEP: begin
            priority if (stat.w_stop) begin
               cmd.op   = pamt_pkg::OP_NEXT_SL;
               state_in = stat.sl_last ? pamt_pkg::S_FIN : pamt_pkg::S_WK_CHILD;
            end else if (stat.w_hit) begin
               cmd.op   = pamt_pkg::OP_KILL;
               state_in = stat.sl_last ? pamt_pkg::S_FIN : pamt_pkg::S_WK_CHILD;
            end else if (stat.w_exh) begin
               cmd.op   = pamt_pkg::OP_NEXT_SL;
               state_in = stat.sl_last ? pamt_pkg::S_FIN : pamt_pkg::S_WK_CHILD;
            end else begin
               cmd.op = pamt_pkg::OP_WALK_STEP;
            end
         end
         pamt_pkg::S_FIN: begin
            cmd.op   = (stat.rtype == pamt_pkg::REQ_RELEASE) ? pamt_pkg::OP_REL_DONE
                                                             : pamt_pkg::OP_REV_DONE;
            state_in = pamt_pkg::S_IDLE;
         end
         default: state_in = pamt_pkg::S_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// File: design/page_alias_mapping_table.sv
// ---------------------------------------------------------------------------
// page_alias_mapping_table: frame and alias slot table with revoke walk
// Top level joining the request sequencer and the table datapath.
// ---------------------------------------------------------------------------
// Usage:
//   A request is taken on the rising edge where start is high and busy is low.
//   Results leave on rsp_item, one per cycle of rsp_strobe; the receiver
//   cannot stall, so each result is valid for exactly one cycle. The final
//   result of a request has last set.
//   Get scans frame use counts, a read and a check state per frame, until
//   it finds a free frame or has checked the last frame.
//   Alias, revoke and release first search the table: a read and a check
//   state per frame use count, and a read and a check state per slot of
//   each live frame. Alias then scans the found frame, a read and a check
//   state per slot. Revoke and release copy the frame, a read and a capture
//   state per slot, then walk each slot's parent chain, one link per cycle,
//   up to 32 links a slot. The registered memory reads set these steps.
//   Each result shows in the cycle after its decision; busy drops with the
//   final one.
//   After reset the block sweeps all 8192 slots clear, one a cycle, with busy
//   high; requests are taken only after that pass.
// ---------------------------------------------------------------------------
`default_nettype none

module page_alias_mapping_table (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output      logic                   busy,
   input  wire pamt_pkg::req_item_type req_item,
   output      logic                   rsp_strobe,
   output      pamt_pkg::rsp_item_type rsp_item
);

   pamt_pkg::cmd_type  cmd;
   pamt_pkg::stat_type stat;

   pamt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   pamt_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

`default_nettype wire

// File: design/pamt_checker.sv
// ---------------------------------------------------------------------------
// pamt_checker: port-level checks for the mapping table
// Bound to the top level; watches request and result ports over time.
// ---------------------------------------------------------------------------
`default_nettype none

module pamt_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   start,
   input wire logic                   busy,
   input wire logic                   rsp_strobe,
   input wire pamt_pkg::rsp_item_type rsp_item
);

   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low after reset");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request accepted without going busy");

   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.last |-> busy)
      else $error("non-final result while idle");

   a_mid_revoke: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.last |-> rsp_item.is_revoke &&
                                       rsp_item.status == pamt_pkg::CODE_OK)
      else $error("non-final result is not a revoke command");

   a_revoke_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.is_revoke |-> rsp_item.mapped_vaddr == '0)
      else $error("revoke command carries a mapped address");

endmodule

bind page_alias_mapping_table pamt_checker u_pamt_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);

`default_nettype wire

// File: verif/page_alias_mapping_table_checker.sv
// ---------------------------------------------------------------------------
// page_alias_mapping_table_checker: result predictor and scoreboard
// Watches the request and response channels. For each accepted request it
// updates its own copy of the frame and slot table and queues the expected
// responses. Each strobed response is then compared, field by field, with
// the oldest expected response.
// ---------------------------------------------------------------------------
`default_nettype none

module page_alias_mapping_table_checker
   import pamt_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic         busy,
   input  wire req_item_type req_item,
   input  wire logic         rsp_strobe,
   input  wire rsp_item_type rsp_item,
   output int                mismatches,
   output int                pending
);

   logic [15:0]   tbl_owner [TOTAL_SLOTS];
   logic [31:0]   tbl_vaddr [TOTAL_SLOTS];
   logic [PW-1:0] tbl_parent [TOTAL_SLOTS];
   logic [5:0]    use_count [NUM_FRAMES];

   rsp_item_type expected_rsp_q[$];

   initial begin
      mismatches = 0;
      pending    = 0;
   end

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %0h expected %0h", field, got, want);
      mismatches++;
   endtask

   task automatic clear_table();
      for (int i = 0; i < TOTAL_SLOTS; i++) begin
         tbl_owner[i]  = '0;
         tbl_vaddr[i]  = '0;
         tbl_parent[i] = '0;
      end
      for (int f = 0; f < NUM_FRAMES; f++) use_count[f] = '0;
   endtask

   task automatic push_rsp(input code_type status, input logic [31:0] mapped,
                           input int f, input int s, input logic revoke,
                           input logic [15:0] rowner, input logic [31:0] rvaddr,
                           input logic last);
      rsp_item_type r;
      r.status       = status;
      r.mapped_vaddr = mapped;
      r.frame        = f[7:0];
      r.slot         = s[4:0];
      r.is_revoke    = revoke;
      r.revoke_owner = rowner;
      r.revoke_vaddr = rvaddr;
      r.last         = last;
      expected_rsp_q.push_back(r);
   endtask

   function automatic bit lookup(input logic [15:0] o, input logic [31:0] v,
                                 output int fr, output int sl);
      fr = 0;
      sl = 0;
      if (o == 0) return 0;
      for (int f = 0; f < NUM_FRAMES; f++) begin
         if (use_count[f] == 0) continue;
         for (int s = 0; s < SLOTS_PER_FRAME; s++)
            if (tbl_owner[f*SLOTS_PER_FRAME+s] == o && tbl_vaddr[f*SLOTS_PER_FRAME+s] == v) begin
               fr = f;
               sl = s;
               return 1;
            end
      end
      return 0;
   endfunction

   function automatic bit under(input int base, input int anc, input int child);
      int c;
      int p;
      c = child;
      for (int n = 0; n < SLOTS_PER_FRAME; n++) begin
         p = int'(tbl_parent[base+c]);
         if (p >= SLOTS_PER_FRAME || p == c) return 0;
         if (p == anc) return 1;
         c = p;
      end
      return 0;
   endfunction

   task automatic free_entry(input int f, input int s);
      tbl_owner[f*SLOTS_PER_FRAME+s]  = '0;
      tbl_vaddr[f*SLOTS_PER_FRAME+s]  = '0;
      tbl_parent[f*SLOTS_PER_FRAME+s] = '0;
      if (use_count[f] != 0) use_count[f]--;
   endtask

   task automatic predict_mapping(input req_item_type r);
      int  f;
      int  s;
      int  d;
      int  base;
      bit  hit;
      bit  kill [SLOTS_PER_FRAME];
      f = 0;
      s = 0;
      case (rtype_type'(r.req_type))
         REQ_GET: begin
            if (r.owner == 0 || r.vaddr == 0) begin
               push_rsp(CODE_REFUSED, 0, 0, 0, 0, 0, 0, 1);
               return;
            end
            while (f < NUM_FRAMES && use_count[f] != 0) f++;
            if (f >= NUM_FRAMES) push_rsp(CODE_NO_FRAME, 0, 0, 0, 0, 0, 0, 1);
            else if (!r.grant_ok) push_rsp(CODE_REFUSED, 0, f, 0, 0, 0, 0, 1);
            else begin
               tbl_owner[f*SLOTS_PER_FRAME]  = r.owner;
               tbl_vaddr[f*SLOTS_PER_FRAME]  = r.vaddr;
               tbl_parent[f*SLOTS_PER_FRAME] = '0;
               use_count[f] = 1;
               push_rsp(CODE_OK, r.vaddr, f, 0, 0, 0, 0, 1);
            end
         end
         REQ_ALIAS: begin
            if (!lookup(r.owner, r.vaddr, f, s)) begin
               push_rsp(CODE_NO_SOURCE, 0, 0, 0, 0, 0, 0, 1);
               return;
            end
            base = f * SLOTS_PER_FRAME;
            for (d = 0; d < SLOTS_PER_FRAME; d++)
               if (d != s && tbl_owner[base+d] == 0) break;
            if (d >= SLOTS_PER_FRAME) push_rsp(CODE_NO_SLOT, 0, f, s, 0, 0, 0, 1);
            else if (r.dest_owner == 0 || r.dest_vaddr == 0 || !r.grant_ok)
               push_rsp(CODE_REFUSED, 0, f, d, 0, 0, 0, 1);
            else begin
               tbl_owner[base+d]  = r.dest_owner;
               tbl_vaddr[base+d]  = r.dest_vaddr;
               tbl_parent[base+d] = s[PW-1:0];
               use_count[f]++;
               push_rsp(CODE_OK, r.dest_vaddr, f, d, 0, 0, 0, 1);
            end
         end
         default: begin
            if (!lookup(r.owner, r.vaddr, f, s)) begin
               push_rsp(CODE_NOT_FOUND, 0, 0, 0, 0, 0, 0, 1);
               return;
            end
            base = f * SLOTS_PER_FRAME;
            for (int c = 0; c < SLOTS_PER_FRAME; c++) begin
               kill[c] = c != s && tbl_owner[base+c] != 0 && under(base, s, c);
               if (kill[c])
                  push_rsp(CODE_OK, 0, f, c, 1, tbl_owner[base+c], tbl_vaddr[base+c], 0);
            end
            for (int c = 0; c < SLOTS_PER_FRAME; c++)
               if (kill[c]) free_entry(f, c);
            if (rtype_type'(r.req_type) == REQ_REVOKE)
               push_rsp(CODE_OK, 0, f, s, 0, 0, 0, 1);
            else begin
               push_rsp(CODE_OK, 0, f, s, 1, tbl_owner[base+s], tbl_vaddr[base+s], 1);
               free_entry(f, s);
            end
         end
      endcase
   endtask

   task automatic check_rsp(input rsp_item_type got);
      rsp_item_type want;
      if (expected_rsp_q.size() == 0) begin
         report_mismatch("unexpected response", 32'(got.status), 32'(0));
         return;
      end
      want = expected_rsp_q.pop_front();
      if (got.status != want.status)
         report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.mapped_vaddr != want.mapped_vaddr)
         report_mismatch("mapped_vaddr", got.mapped_vaddr, want.mapped_vaddr);
      if (got.frame != want.frame)
         report_mismatch("frame", 32'(got.frame), 32'(want.frame));
      if (got.slot != want.slot)
         report_mismatch("slot", 32'(got.slot), 32'(want.slot));
      if (got.is_revoke != want.is_revoke)
         report_mismatch("is_revoke", 32'(got.is_revoke), 32'(want.is_revoke));
      if (got.revoke_owner != want.revoke_owner)
         report_mismatch("revoke_owner", 32'(got.revoke_owner), 32'(want.revoke_owner));
      if (got.revoke_vaddr != want.revoke_vaddr)
         report_mismatch("revoke_vaddr", got.revoke_vaddr, want.revoke_vaddr);
      if (got.last != want.last)
         report_mismatch("last", 32'(got.last), 32'(want.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_table();
         expected_rsp_q.delete();
      end else begin
         if (rsp_strobe) check_rsp(rsp_item);
         if (start && !busy) predict_mapping(req_item);
      end
      pending = expected_rsp_q.size();
   end

endmodule

`default_nettype wire

// File: verif/page_alias_mapping_table_tb.sv
// ---------------------------------------------------------------------------
// page_alias_mapping_table_tb: stimulus and verdict for the mapping table
// Directed requests cover invalid domains, refused grants, missing sources,
// chained aliases and revoke walks. Random get/alias/revoke/release chains
// follow under changing sender gaps, then the table is driven full.
// ---------------------------------------------------------------------------
`default_nettype none

module page_alias_mapping_table_tb;
   import pamt_pkg::*;

   localparam int WATCHDOG_LIMIT = 100000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_item_type req_item = '0;
   logic         rsp_strobe;
   rsp_item_type rsp_item;
   int           mismatches;
   int           pending;
   int           idle_pct = 24;
   int           sent = 0;
   int           stall_cycles = 0;
   logic [15:0]  pool_owner[$];
   logic [31:0]  pool_vaddr[$];

   page_alias_mapping_table u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   page_alias_mapping_table_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic req_item_type mk(input rtype_type t, input logic [15:0] o,
                                       input logic [31:0] v, input logic [15:0] dst_o,
                                       input logic [31:0] dv, input logic g);
      req_item_type r;
      r.req_type   = t;
      r.owner      = o;
      r.vaddr      = v;
      r.dest_owner = dst_o;
      r.dest_vaddr = dv;
      r.grant_ok   = g;
      return r;
   endfunction

   function automatic logic [15:0] pick_owner();
      int k;
      k = $urandom_range(0, 99);
      if (k < 3) return 16'h0;
      if (k < 12) return 16'($urandom_range(0, 65535));
      return 16'($urandom_range(1, 6));
   endfunction

   function automatic logic [31:0] pick_vaddr();
      int k;
      k = $urandom_range(0, 99);
      if (k < 3) return 32'h0;
      if (k < 12) return $urandom;
      return 32'h1000 * $urandom_range(1, 8);
   endfunction

   task automatic send(input req_item_type it);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_item <= it;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      sent++;
      if (it.req_type == REQ_GET) begin
         pool_owner.push_back(it.owner);
         pool_vaddr.push_back(it.vaddr);
      end else if (it.req_type == REQ_ALIAS) begin
         pool_owner.push_back(it.dest_owner);
         pool_vaddr.push_back(it.dest_vaddr);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic run_chain();
      logic [15:0] own[$];
      logic [31:0] va[$];
      int          k;
      int          j;
      rtype_type   t;
      own.push_back(pick_owner());
      va.push_back(pick_vaddr());
      send(mk(REQ_GET, own[0], va[0], 16'($urandom), $urandom,
              $urandom_range(0, 9) != 0));
      k = ($urandom_range(0, 3) == 0) ? $urandom_range(28, 34) : $urandom_range(0, 6);
      repeat (k) begin
         j = $urandom_range(0, own.size() - 1);
         own.push_back(pick_owner());
         va.push_back(pick_vaddr());
         send(mk(REQ_ALIAS, own[j], va[j], own[own.size()-1], va[va.size()-1],
                 $urandom_range(0, 9) != 0));
      end
      repeat ($urandom_range(1, 2)) begin
         j = $urandom_range(0, own.size() - 1);
         t = $urandom_range(0, 1) ? REQ_REVOKE : REQ_RELEASE;
         send(mk(t, own[j], va[j], 16'($urandom), $urandom, $urandom_range(0, 1) != 0));
      end
      if ($urandom_range(0, 4) == 0)
         send(mk(rtype_type'($urandom_range(0, 3)), 16'($urandom), $urandom,
                 16'($urandom), $urandom, $urandom_range(0, 1) != 0));
      if ($urandom_range(0, 2) == 0 && pool_owner.size() != 0) begin
         j = $urandom_range(0, pool_owner.size() - 1);
         send(mk(rtype_type'($urandom_range(1, 3)), pool_owner[j], pool_vaddr[j],
                 pick_owner(), pick_vaddr(), $urandom_range(0, 1) != 0));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send(mk(REQ_GET, 16'hFFFF, 32'hFFFF_FFFF, 16'h0, 32'h0, 1'b1));
      send(mk(REQ_GET, 16'h0, 32'h2000, 16'h0, 32'h0, 1'b1));
      send(mk(REQ_GET, 16'h7, 32'h0, 16'h0, 32'h0, 1'b1));
      send(mk(REQ_GET, 16'h7, 32'h7000, 16'h0, 32'h0, 1'b0));
      send(mk(REQ_ALIAS, 16'hFFFF, 32'hFFFF_FFFF, 16'h1, 32'h1, 1'b1));
      send(mk(REQ_ALIAS, 16'hFFFF, 32'hFFFF_FFFF, 16'h0, 32'h3000, 1'b1));
      send(mk(REQ_ALIAS, 16'hFFFF, 32'hFFFF_FFFF, 16'h3, 32'h0, 1'b1));
      send(mk(REQ_ALIAS, 16'hFFFF, 32'hFFFF_FFFF, 16'h3, 32'h3000, 1'b0));
      send(mk(REQ_ALIAS, 16'h9, 32'h9000, 16'h3, 32'h3000, 1'b1));
      send(mk(REQ_ALIAS, 16'h0, 32'hFFFF_FFFF, 16'h3, 32'h3000, 1'b1));
      send(mk(REQ_ALIAS, 16'h1, 32'h1, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
      send(mk(REQ_ALIAS, 16'hFFFF, 32'hFFFF_FFFF, 16'h2, 32'h2, 1'b1));
      send(mk(REQ_REVOKE, 16'h9, 32'h9000, 16'h0, 32'h0, 1'b0));
      send(mk(REQ_REVOKE, 16'hFFFF, 32'hFFFF_FFFF, 16'h0, 32'h0, 1'b0));
      send(mk(REQ_RELEASE, 16'h9, 32'h9000, 16'h0, 32'h0, 1'b0));
      send(mk(REQ_GET, 16'h5, 32'h5000, 16'h0, 32'h0, 1'b1));
      send(mk(REQ_ALIAS, 16'h5, 32'h5000, 16'h6, 32'h6000, 1'b1));
      send(mk(REQ_RELEASE, 16'h5, 32'h5000, 16'h0, 32'h0, 1'b1));
      send(mk(REQ_REVOKE, 16'h0, 32'h0, 16'h0, 32'h0, 1'b1));
      send(mk(REQ_RELEASE, 16'hFFFF, 32'hFFFF_FFFF, 16'h0, 32'h0, 1'b1));
      drain();

      while (sent < 35) run_chain();
      drain();
      idle_pct = 66;
      while (sent < 50) run_chain();
      idle_pct = 0;
      while (sent < 65) run_chain();

      repeat (NUM_FRAMES + 4)
         send(mk(REQ_GET, 16'($urandom_range(1, 65535)), $urandom | 32'h1, 16'h0,
                 32'h0, 1'b1));
      send(mk(REQ_ALIAS, 16'h1234, 32'h55AA_55AA, 16'h1, 32'h1, 1'b1));
      send(mk(REQ_REVOKE, 16'h1234, 32'h55AA_55AA, 16'h0, 32'h0, 1'b1));

      drain();
      repeat (200) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: sim.f
design/pamt_pkg.sv
design/pamt_ram.sv
design/pamt_datapath.sv
design/pamt_ctrl.sv
design/page_alias_mapping_table.sv
design/pamt_checker.sv
verif/page_alias_mapping_table_checker.sv
verif/page_alias_mapping_table_tb.sv
